[rtl/wmo_pkg.sv]
// Shared types and constants for the wide multiply with overflow flag.
package wmo_pkg;

  localparam int WORD_W = 64;
  localparam int HALF_W = 32;
  localparam int WIDE_W = 2 * WORD_W;

  // Sequencer states, one-hot
  typedef enum logic [5:0] {
    ST_LOAD    = 6'b000001,
    ST_MUL     = 6'b000010,
    ST_DRAIN   = 6'b000100,
    ST_EMIT_RD = 6'b001000,
    ST_EMIT_LD = 6'b010000,
    ST_EMIT_OUT = 6'b100000
  } state_t;

  // Kind of step travelling down the multiply-accumulate pipeline
  typedef enum logic {
    OP_PROD  = 1'b0,  // a[i]*b[j] + acc[i+j] + carry
    OP_CARRY = 1'b1   // row end: store the running carry
  } op_t;

  typedef struct packed {
    logic valid;
    op_t  op;
    logic first_row;  // accumulator word not yet written, reads as zero
  } step_ctrl_t;

endpackage

[rtl/wide_multiply_overflow_core.sv]
// Top level of the multiword unsigned multiplier with truncation flag.
// WORDS requests on the input stream load the two operands one 64-bit word
// each (a_word in tdata[63:0], b_word in tdata[127:64]), least significant
// first. The last load starts the schoolbook product: one 64x64 word product
// is issued per cycle into a three-stage multiply-accumulate pipeline built on
// four 32x32 multipliers, walking rows of WORDS products plus one carry store,
// and the pipeline drains before output begins. A step stalls only when it
// reads an accumulator word still in the pipeline, which happens for WORDS of
// 2 or 3. The low WORDS product words then leave on the output stream one at
// a time when the sink is ready, each read from the single read port of the
// accumulator memory before it is registered; tlast marks the final word and
// tuser carries the overflow flag on it. Loading of the next operands overlaps
// result output, except for the word that would start the next multiply.
module wide_multiply_overflow_core
  import wmo_pkg::*;
#(
  parameter int WORDS = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,   // [63:0] a_word, [127:64] b_word
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [63:0]  m_axis_tdata,   // [63:0] product_word
  output logic         m_axis_tlast,   // last_word
  output logic         m_axis_tuser    // [0] overflow
);

  localparam int OPA_W  = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int STEP_W = $clog2(WORDS + 1);
  localparam int ADDR_W = $clog2(2 * WORDS);

  state_t                state;
  logic [OPA_W-1:0]      load_count;
  logic [OPA_W-1:0]      row;
  logic [STEP_W-1:0]     col;
  logic [OPA_W-1:0]      emit_idx;
  logic                  ovf;

  logic [WORD_W-1:0]     a_mem   [WORDS];
  logic [WORD_W-1:0]     b_mem   [WORDS];
  logic [WORD_W-1:0]     acc_mem [2*WORDS];
  logic [WORD_W-1:0]     a_rd, b_rd, acc_rd;

  logic                  in_req;
  logic                  load_last;
  logic                  emitting;
  logic                  carry_step;
  logic                  row_last;
  logic [OPA_W-1:0]      b_raddr;
  logic [ADDR_W-1:0]     step_addr;
  logic [ADDR_W-1:0]     acc_raddr;
  logic                  hazard, busy;
  logic                  issue_ok;
  step_ctrl_t            issue;
  logic                  wr_en;
  logic [ADDR_W-1:0]     wr_addr;
  logic [WORD_W-1:0]     wr_data;

  // input side
  assign load_last     = (load_count == OPA_W'(WORDS - 1));
  assign emitting      = (state == ST_EMIT_RD) || (state == ST_EMIT_LD)
                      || (state == ST_EMIT_OUT);
  assign s_axis_tready = (state == ST_LOAD) || (emitting && !load_last);
  assign in_req        = s_axis_tvalid && s_axis_tready;

  // step sequencing over rows and columns
  assign carry_step = (col == STEP_W'(WORDS));
  assign row_last   = (row == OPA_W'(WORDS - 1));
  assign step_addr  = carry_step ? ADDR_W'(row) + ADDR_W'(WORDS)
                                 : ADDR_W'(row) + ADDR_W'(col);
  assign b_raddr    = carry_step ? '0 : col[OPA_W-1:0];
  assign issue_ok   = (state == ST_MUL)
                   && (carry_step || row == '0 || !hazard);

  always_comb begin
    issue           = '0;
    issue.valid     = issue_ok;
    issue.op        = carry_step ? OP_CARRY : OP_PROD;
    issue.first_row = (row == '0);
  end

  assign acc_raddr = (state == ST_MUL) ? step_addr : ADDR_W'(emit_idx);

  // operand memories: written by loads, read by the sequencer
  always_ff @(posedge clk) begin
    if (in_req) begin
      a_mem[load_count] <= s_axis_tdata[WORD_W-1:0];
      b_mem[load_count] <= s_axis_tdata[2*WORD_W-1:WORD_W];
    end
    a_rd <= a_mem[row];
    b_rd <= b_mem[b_raddr];
  end

  // accumulator memory: pipeline write-back, one read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      acc_mem[wr_addr] <= wr_data;
    end
    acc_rd <= acc_mem[acc_raddr];
  end

  wmo_mac #(
    .ADDR_W (ADDR_W)
  ) u_mac (
    .clk        (clk),
    .rst        (rst),
    .issue      (issue),
    .issue_addr (step_addr),
    .a_data     (a_rd),
    .b_data     (b_rd),
    .acc_data   (acc_rd),
    .query_addr (step_addr),
    .hazard     (hazard),
    .busy       (busy),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data)
  );

  // load counter
  always_ff @(posedge clk) begin
    if (rst) begin
      load_count <= '0;
    end else if (in_req) begin
      load_count <= load_last ? '0 : load_count + OPA_W'(1);
    end
  end

  // upper words only grow, so any nonzero write there means overflow
  always_ff @(posedge clk) begin
    if (rst) begin
      ovf <= 1'b0;
    end else if (state == ST_LOAD && in_req && load_last) begin
      ovf <= 1'b0;
    end else if (wr_en && wr_addr >= ADDR_W'(WORDS) && wr_data != '0) begin
      ovf <= 1'b1;
    end
  end

  // main sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_LOAD;
      row           <= '0;
      col           <= '0;
      emit_idx      <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      unique case (state)
        ST_LOAD: begin
          if (in_req && load_last) begin
            row   <= '0;
            col   <= '0;
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          if (issue_ok) begin
            if (carry_step) begin
              col <= '0;
              row <= row + OPA_W'(1);
              if (row_last) begin
                state <= ST_DRAIN;
              end
            end else begin
              col <= col + STEP_W'(1);
            end
          end
        end
        ST_DRAIN: begin
          if (!busy) begin
            emit_idx <= '0;
            state    <= ST_EMIT_RD;
          end
        end
        ST_EMIT_RD: begin
          state <= ST_EMIT_LD;
        end
        ST_EMIT_LD: begin
          m_axis_tvalid <= 1'b1;
          state         <= ST_EMIT_OUT;
        end
        ST_EMIT_OUT: begin
          if (m_axis_tready) begin
            m_axis_tvalid <= 1'b0;
            if (m_axis_tlast) begin
              state <= ST_LOAD;
            end else begin
              emit_idx <= emit_idx + OPA_W'(1);
              state    <= ST_EMIT_RD;
            end
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (state == ST_EMIT_LD) begin
      m_axis_tdata <= acc_rd;
      m_axis_tlast <= (emit_idx == OPA_W'(WORDS - 1));
      m_axis_tuser <= (emit_idx == OPA_W'(WORDS - 1)) && ovf;
    end
  end

endmodule

[rtl/wmo_mac.sv]
// Three-stage 64x64 multiply-accumulate pipeline with row carry and hazard check.
module wmo_mac
  import wmo_pkg::*;
#(
  parameter int ADDR_W = 3
) (
  input  logic                clk,
  input  logic                rst,
  // step issue; operand and accumulator data arrive in the cycle after
  input  step_ctrl_t          issue,
  input  logic [ADDR_W-1:0]   issue_addr,
  input  logic [WORD_W-1:0]   a_data,
  input  logic [WORD_W-1:0]   b_data,
  input  logic [WORD_W-1:0]   acc_data,
  // read-after-write check against steps in flight
  input  logic [ADDR_W-1:0]   query_addr,
  output logic                hazard,
  output logic                busy,
  // accumulator write-back
  output logic                wr_en,
  output logic [ADDR_W-1:0]   wr_addr,
  output logic [WORD_W-1:0]   wr_data
);

  step_ctrl_t              c1, c2, c3;
  logic [ADDR_W-1:0]       addr1, addr2, addr3;
  logic [WORD_W-1:0]       p0, p1, p2, p3;
  logic [WORD_W-1:0]       acc2, acc3;
  logic [WIDE_W-1:0]       prod3;
  logic [WORD_W-1:0]       carry;
  logic [WIDE_W-1:0]       prod_next;
  logic [WIDE_W-1:0]       sum;

  // control pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      c1 <= '0;
      c2 <= '0;
      c3 <= '0;
    end else begin
      c1 <= issue;
      c2 <= c1;
      c3 <= c2;
    end
  end

  // stage 1: four 32x32 partial products
  always_ff @(posedge clk) begin
    addr1 <= issue_addr;
    addr2 <= addr1;
    addr3 <= addr2;
    p0    <= 64'(a_data[HALF_W-1:0])      * 64'(b_data[HALF_W-1:0]);
    p1    <= 64'(a_data[HALF_W-1:0])      * 64'(b_data[WORD_W-1:HALF_W]);
    p2    <= 64'(a_data[WORD_W-1:HALF_W]) * 64'(b_data[HALF_W-1:0]);
    p3    <= 64'(a_data[WORD_W-1:HALF_W]) * 64'(b_data[WORD_W-1:HALF_W]);
    acc2  <= c1.first_row ? '0 : acc_data;
  end

  // stage 2: combine into the 128-bit word product
  assign prod_next = {p3, p0}
                   + {{HALF_W{1'b0}}, p1, {HALF_W{1'b0}}}
                   + {{HALF_W{1'b0}}, p2, {HALF_W{1'b0}}};

  always_ff @(posedge clk) begin
    prod3 <= prod_next;
    acc3  <= acc2;
  end

  // stage 3: add accumulator word and running carry; never exceeds 128 bits
  assign sum = prod3 + {{WORD_W{1'b0}}, acc3} + {{WORD_W{1'b0}}, carry};

  always_ff @(posedge clk) begin
    if (rst) begin
      carry <= '0;
    end else if (c3.valid) begin
      if (c3.op == OP_CARRY) begin
        carry <= '0;
      end else begin
        carry <= sum[WIDE_W-1:WORD_W];
      end
    end
  end

  assign wr_en   = c3.valid;
  assign wr_addr = addr3;
  assign wr_data = (c3.op == OP_CARRY) ? carry : sum[WORD_W-1:0];

  // a read of an address still in flight would see a stale word
  assign hazard = (c1.valid && addr1 == query_addr)
               || (c2.valid && addr2 == query_addr)
               || (c3.valid && addr3 == query_addr);
  assign busy   = c1.valid || c2.valid || c3.valid;

endmodule
